// File: src/tcps_pkg.sv
// Shared types, constants and helpers for the two-class priority service scheduler.
// Used by tcps_fifo, tcps_stats and the top level; no dependencies.
package tcps_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ID_W        = 28;
    localparam int STAMP_W     = 32;
    localparam int SVC_W       = 4;
    localparam int SUM_W       = 48;
    localparam int CNT_W       = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 312;

    typedef logic [PTR_W-1:0] ptr_t;

    // queue entry: id in the low bits, then arrival stamp, then service length
    typedef struct packed {
        logic [SVC_W-1:0]   service;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
    } entry_t;

    typedef struct packed {
        logic full;   // full before this tick's enqueue
        logic avail;  // holds an entry after this tick's enqueue
    } qstat_t;

    typedef struct packed {
        logic               arrival;
        logic               arr_priority;
        logic               started;
        logic               st_priority;
        logic [STAMP_W-1:0] wait_ticks;
    } event_t;

    // result, last field in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]   general_arrivals;
        logic [CNT_W-1:0]   priority_arrivals;
        logic [CNT_W-1:0]   all_arrivals;
        logic [SUM_W-1:0]   general_wait_total;
        logic [SUM_W-1:0]   priority_wait_total;
        logic [SUM_W-1:0]   all_wait_total;
        logic               arrival_dropped;
        logic [SVC_W-1:0]   busy_left;
        logic [STAMP_W-1:0] start_wait;
        logic [ID_W-1:0]    start_id;
        logic               start_priority;
        logic               start_valid;
    } result_t;

    localparam int RES_W = $bits(result_t);

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// File: src/tcps_fifo.sv
// One class queue: circular buffer memory with head/tail pointers and a prefetched head entry.
// Depends on tcps_pkg.
module tcps_fifo
    import tcps_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   step,
    input  logic   enq,
    input  entry_t enq_entry,
    input  logic   deq,
    output qstat_t stat,
    output entry_t head_entry
);

    entry_t mem [QUEUE_DEPTH];

    ptr_t   head_reg, tail_reg;
    ptr_t   head_next, tail_next;
    entry_t rd_data_reg;
    entry_t byp_data_reg;
    logic   byp_reg;
    logic   do_wr, do_rd;

    always_comb begin
        stat.full  = (ptr_inc(tail_reg) == head_reg);
        do_wr      = step && enq && !stat.full;
        tail_next  = do_wr ? ptr_inc(tail_reg) : tail_reg;
        stat.avail = (head_reg != tail_next);
        do_rd      = step && deq;
        head_next  = do_rd ? ptr_inc(head_reg) : head_reg;
        // empty at tick start: the head can only be this tick's arrival
        if (head_reg == tail_reg) begin
            head_entry = enq_entry;
        end else if (byp_reg) begin
            head_entry = byp_data_reg;
        end else begin
            head_entry = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[tail_reg] <= enq_entry;
        end
        rd_data_reg  <= mem[head_next];
        byp_data_reg <= enq_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            byp_reg  <= 1'b0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            byp_reg  <= do_wr && (tail_reg == head_next);
        end
    end

endmodule

// File: src/tcps_stats.sv
// Arrival counters and saturating wait sums, per class and overall.
// Depends on tcps_pkg.
module tcps_stats
    import tcps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  event_t           ev,
    output logic [SUM_W-1:0] all_wait_next,
    output logic [SUM_W-1:0] pri_wait_next,
    output logic [SUM_W-1:0] gen_wait_next,
    output logic [CNT_W-1:0] all_arr_next,
    output logic [CNT_W-1:0] pri_arr_next,
    output logic [CNT_W-1:0] gen_arr_next
);

    logic [SUM_W-1:0] all_wait_reg, pri_wait_reg, gen_wait_reg;
    logic [CNT_W-1:0] all_arr_reg, pri_arr_reg, gen_arr_reg;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [STAMP_W-1:0] a);
        logic [SUM_W:0] t;
        t       = {1'b0, s} + (SUM_W+1)'(a);
        sat_add = t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    always_comb begin
        all_arr_next  = all_arr_reg + CNT_W'(ev.arrival);
        pri_arr_next  = pri_arr_reg + CNT_W'(ev.arrival && ev.arr_priority);
        gen_arr_next  = gen_arr_reg + CNT_W'(ev.arrival && !ev.arr_priority);
        all_wait_next = ev.started ? sat_add(all_wait_reg, ev.wait_ticks) : all_wait_reg;
        pri_wait_next = (ev.started && ev.st_priority) ?
                        sat_add(pri_wait_reg, ev.wait_ticks) : pri_wait_reg;
        gen_wait_next = (ev.started && !ev.st_priority) ?
                        sat_add(gen_wait_reg, ev.wait_ticks) : gen_wait_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            all_wait_reg <= '0;
            pri_wait_reg <= '0;
            gen_wait_reg <= '0;
            all_arr_reg  <= '0;
            pri_arr_reg  <= '0;
            gen_arr_reg  <= '0;
        end else if (step) begin
            all_wait_reg <= all_wait_next;
            pri_wait_reg <= pri_wait_next;
            gen_wait_reg <= gen_wait_next;
            all_arr_reg  <= all_arr_next;
            pri_arr_reg  <= pri_arr_next;
            gen_arr_reg  <= gen_arr_next;
        end
    end

endmodule

// File: src/two_class_priority_service_scheduler.sv
// Top level of the two-class strict-priority service scheduler.
// Depends on tcps_pkg, tcps_fifo and tcps_stats.
//
// Each input request is one tick: an optional arrival (class and service length) that is
// stamped, numbered, counted and queued in its class queue (dropped when that queue is full,
// at most QUEUE_DEPTH-1 entries each). When the server is idle the priority queue head starts
// service, else the general queue head. Every tick yields exactly one result request. The block
// takes one tick per clock cycle unless the result side stalls; ticks are held in the input
// register, then the result register. Each queue's prefetched head register sets the rate, with
// the next head entry ready every cycle. Queue memories need no clearing pass after reset.
module two_class_priority_service_scheduler
    import tcps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] arrival_valid, [1] arrival_priority, [5:2] arrival_service
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] start_valid, [1] start_priority, [29:2] start_id, [61:30] start_wait,
    // [65:62] busy_left, [66] arrival_dropped, [114:67] all_wait_total,
    // [162:115] priority_wait_total, [210:163] general_wait_total,
    // [242:211] all_arrivals, [274:243] priority_arrivals, [306:275] general_arrivals
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic               in_valid_reg;
    logic               in_arr_reg, in_pri_reg;
    logic [SVC_W-1:0]   in_svc_reg;
    logic [STAMP_W-1:0] tick_reg;
    logic [ID_W-1:0]    next_id_reg;
    logic [SVC_W-1:0]   remaining_reg, remaining_next;
    logic               out_valid_reg;
    result_t            res_reg, res_next;

    logic               step, idle, deq_p, deq_g;
    entry_t             arr_entry, p_head, g_head, st_entry;
    qstat_t             p_stat, g_stat;
    event_t             ev;
    logic [SUM_W-1:0]   all_wait_sum, pri_wait_sum, gen_wait_sum;
    logic [CNT_W-1:0]   all_arr_cnt, pri_arr_cnt, gen_arr_cnt;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), res_reg};

    always_comb begin
        arr_entry.id      = next_id_reg;
        arr_entry.stamp   = tick_reg;
        arr_entry.service = in_svc_reg;
        idle     = (remaining_reg == '0);
        deq_p    = idle && p_stat.avail;
        deq_g    = idle && !p_stat.avail && g_stat.avail;
        st_entry = deq_p ? p_head : g_head;

        ev.arrival      = in_arr_reg;
        ev.arr_priority = in_pri_reg;
        ev.started      = deq_p || deq_g;
        ev.st_priority  = deq_p;
        ev.wait_ticks   = ev.started ? (tick_reg - st_entry.stamp) : '0;

        if (!idle) begin
            remaining_next = remaining_reg - 1'b1;
        end else if (ev.started) begin
            remaining_next = st_entry.service;
        end else begin
            remaining_next = '0;
        end

        res_next.start_valid         = ev.started;
        res_next.start_priority      = deq_p;
        res_next.start_id            = ev.started ? st_entry.id : '0;
        res_next.start_wait          = ev.wait_ticks;
        res_next.busy_left           = remaining_next;
        res_next.arrival_dropped     = in_arr_reg && (in_pri_reg ? p_stat.full : g_stat.full);
        res_next.all_wait_total      = all_wait_sum;
        res_next.priority_wait_total = pri_wait_sum;
        res_next.general_wait_total  = gen_wait_sum;
        res_next.all_arrivals        = all_arr_cnt;
        res_next.priority_arrivals   = pri_arr_cnt;
        res_next.general_arrivals    = gen_arr_cnt;
    end

    tcps_fifo u_pri_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .enq        (in_arr_reg && in_pri_reg),
        .enq_entry  (arr_entry),
        .deq        (deq_p),
        .stat       (p_stat),
        .head_entry (p_head)
    );

    tcps_fifo u_gen_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .enq        (in_arr_reg && !in_pri_reg),
        .enq_entry  (arr_entry),
        .deq        (deq_g),
        .stat       (g_stat),
        .head_entry (g_head)
    );

    tcps_stats u_stats (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .ev            (ev),
        .all_wait_next (all_wait_sum),
        .pri_wait_next (pri_wait_sum),
        .gen_wait_next (gen_wait_sum),
        .all_arr_next  (all_arr_cnt),
        .pri_arr_next  (pri_arr_cnt),
        .gen_arr_next  (gen_arr_cnt)
    );

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_arr_reg <= s_axis_tdata[0];
            in_pri_reg <= s_axis_tdata[1];
            in_svc_reg <= s_axis_tdata[5:2];
        end
        if (step) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
            next_id_reg   <= '0;
            remaining_reg <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
                tick_reg      <= tick_reg + 1'b1;
                next_id_reg   <= next_id_reg + ID_W'(in_arr_reg);
                remaining_reg <= remaining_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_countdown: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (remaining_reg != '0) |=> remaining_reg == SVC_W'($past(remaining_reg) - 1'b1))
        else $error("service countdown did not decrement");

    a_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> tick_reg == $past(tick_reg) + 1'b1)
        else $error("tick stamp did not advance on a processed request");

    a_work_conserving: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (remaining_reg == '0) && (p_stat.avail || g_stat.avail)
        |=> m_axis_tvalid && res_reg.start_valid)
        else $error("idle server with a queued customer did not start service");

    a_strict_priority: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (remaining_reg == '0) && p_stat.avail |=> res_reg.start_priority)
        else $error("general customer started while priority queue was not empty");
`endif

endmodule

// File: dv/two_class_priority_service_scheduler_tb.sv
// Testbench for two_class_priority_service_scheduler: drives tick requests over the input
// stream and checks every result request against typed rows or the bench's scheduling predictor.
// Depends on tcps_pkg and the scheduler RTL.
module two_class_priority_service_scheduler_tb;
    import tcps_pkg::*;

    localparam bit CLASS_PRI  = 1'b1;
    localparam bit CLASS_GEN  = 1'b0;
    localparam int STALL_LIMIT = 5000;
    localparam int TICK_TARGET = 1400;
    localparam logic [SUM_W-1:0] SUM_CEIL = '1;

    typedef enum int {LOAD_LIGHT, LOAD_MIXED, LOAD_PRI_FLOOD, LOAD_GEN_FLOOD, LOAD_DRAIN} load_t;

    typedef struct {
        logic [IN_TDATA_W-1:0] req;
        bit                    known;
        result_t               res;
    } drill_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // scheduling predictor state
    entry_t             pri_mem [QUEUE_DEPTH];
    entry_t             gen_mem [QUEUE_DEPTH];
    int                 pri_head, pri_tail, gen_head, gen_tail;
    logic [SVC_W-1:0]   svc_left;
    logic [STAMP_W-1:0] tick_now;
    logic [ID_W-1:0]    id_next;
    logic [SUM_W-1:0]   sum_all, sum_pri, sum_gen;
    logic [CNT_W-1:0]   arr_all, arr_pri, arr_gen;

    result_t    expected_results[$];
    drill_row_t drill_rows[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         rx_hold = 0;
    bit         rx_steady = 1'b0;
    int         n_ticks = 0, n_starts = 0, n_pri_starts = 0, n_drops = 0;

    two_class_priority_service_scheduler dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [IN_TDATA_W-1:0] pack_tick(input bit v, input bit p,
                                                        input logic [SVC_W-1:0] svc);
        pack_tick = {2'b00, svc, p, v};
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] sum,
                                                 input logic [STAMP_W-1:0] add);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + (SUM_W+1)'(add);
        sat_sum = s[SUM_W] ? SUM_CEIL : s[SUM_W-1:0];
    endfunction

    function automatic int gap_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            gap_cycles = 0;
        else if (pick < 85)
            gap_cycles = $urandom_range(1, 3);
        else if (pick < 95)
            gap_cycles = $urandom_range(4, 10);
        else
            gap_cycles = $urandom_range(20, 60);
    endfunction

    // one tick: enqueue the arrival, then count down or start the next customer
    function automatic result_t schedule_tick(input logic [IN_TDATA_W-1:0] req);
        result_t r;
        entry_t  e;
        r = '0;
        e = '0;
        if (req[0]) begin
            e.id = id_next;
            e.stamp = tick_now;
            e.service = req[5:2];
            id_next = id_next + 1'b1;
            arr_all = arr_all + 1'b1;
            if (req[1] == CLASS_PRI) begin
                arr_pri = arr_pri + 1'b1;
                if ((pri_tail + 1) % QUEUE_DEPTH == pri_head) begin
                    r.arrival_dropped = 1'b1;
                end else begin
                    pri_mem[pri_tail] = e;
                    pri_tail = (pri_tail + 1) % QUEUE_DEPTH;
                end
            end else begin
                arr_gen = arr_gen + 1'b1;
                if ((gen_tail + 1) % QUEUE_DEPTH == gen_head) begin
                    r.arrival_dropped = 1'b1;
                end else begin
                    gen_mem[gen_tail] = e;
                    gen_tail = (gen_tail + 1) % QUEUE_DEPTH;
                end
            end
        end
        if (svc_left != 0) begin
            svc_left = svc_left - 1'b1;
        end else begin
            if (pri_head != pri_tail) begin
                e = pri_mem[pri_head];
                pri_head = (pri_head + 1) % QUEUE_DEPTH;
                r.start_valid = 1'b1;
                r.start_priority = CLASS_PRI;
            end else if (gen_head != gen_tail) begin
                e = gen_mem[gen_head];
                gen_head = (gen_head + 1) % QUEUE_DEPTH;
                r.start_valid = 1'b1;
                r.start_priority = CLASS_GEN;
            end
            if (r.start_valid) begin
                r.start_id = e.id;
                r.start_wait = tick_now - e.stamp;
                svc_left = e.service;
                sum_all = sat_sum(sum_all, r.start_wait);
                if (r.start_priority == CLASS_PRI)
                    sum_pri = sat_sum(sum_pri, r.start_wait);
                else
                    sum_gen = sat_sum(sum_gen, r.start_wait);
            end
        end
        tick_now = tick_now + 1'b1;
        r.busy_left = svc_left;
        r.all_wait_total = sum_all;
        r.priority_wait_total = sum_pri;
        r.general_wait_total = sum_gen;
        r.all_arrivals = arr_all;
        r.priority_arrivals = arr_pri;
        r.general_arrivals = arr_gen;
        schedule_tick = r;
    endfunction

    function automatic result_t hand_result(input bit sv, input bit sp, input int id,
                                            input int wt, input int busy, input bit drop,
                                            input int aw, input int pw, input int gw,
                                            input int aa, input int pa, input int ga);
        result_t r;
        r = '0;
        r.start_valid = sv;
        r.start_priority = sp;
        r.start_id = ID_W'(id);
        r.start_wait = STAMP_W'(wt);
        r.busy_left = SVC_W'(busy);
        r.arrival_dropped = drop;
        r.all_wait_total = SUM_W'(aw);
        r.priority_wait_total = SUM_W'(pw);
        r.general_wait_total = SUM_W'(gw);
        r.all_arrivals = CNT_W'(aa);
        r.priority_arrivals = CNT_W'(pa);
        r.general_arrivals = CNT_W'(ga);
        hand_result = r;
    endfunction

    function automatic drill_row_t row(input int v, input bit p, input logic [SVC_W-1:0] svc,
                                       input int known, input result_t res);
        drill_row_t d;
        d.req = pack_tick(v != 0, p, svc);
        d.known = (known != 0);
        d.res = res;
        row = d;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_tick(input load_t mode);
        bit               v, p;
        logic [SVC_W-1:0] svc;
        v = 1'($urandom_range(0, 1));
        p = 1'($urandom_range(0, 1));
        svc = SVC_W'($urandom_range(0, 15));
        case (mode)
            LOAD_LIGHT: v = ($urandom_range(0, 7) == 0);
            LOAD_MIXED: begin end
            LOAD_PRI_FLOOD: begin
                v = ($urandom_range(0, 9) != 0);
                p = ($urandom_range(0, 9) != 0) ? CLASS_PRI : CLASS_GEN;
                svc = SVC_W'($urandom_range(1, 4));
            end
            LOAD_GEN_FLOOD: begin
                v = ($urandom_range(0, 9) != 0);
                p = ($urandom_range(0, 9) == 0) ? CLASS_PRI : CLASS_GEN;
                svc = SVC_W'($urandom_range(1, 4));
            end
            LOAD_DRAIN: v = 1'b0;
            default: v = 1'b0;
        endcase
        random_tick = pack_tick(v, p, svc);
    endfunction

    task automatic issue_tick(input logic [IN_TDATA_W-1:0] req, input bit known,
                              input result_t known_res, input int gap);
        result_t r;
        s_axis_tdata <= req;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        r = schedule_tick(req);
        n_ticks++;
        n_starts += r.start_valid;
        n_pri_starts += (r.start_valid && r.start_priority == CLASS_PRI);
        n_drops += r.arrival_dropped;
        expected_results.push_back(known ? known_res : r);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] seen);
        if (want !== seen) begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // result side: random back-pressure, runs of steady ready when asked
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= gap_cycles();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t seen, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen = result_t'(m_axis_tdata[RES_W-1:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result request, expected none, actual 0x%0h",
                         $time, seen);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                report_field("start_valid", 64'(want.start_valid), 64'(seen.start_valid));
                report_field("start_priority", 64'(want.start_priority),
                             64'(seen.start_priority));
                report_field("start_id", 64'(want.start_id), 64'(seen.start_id));
                report_field("start_wait", 64'(want.start_wait), 64'(seen.start_wait));
                report_field("busy_left", 64'(want.busy_left), 64'(seen.busy_left));
                report_field("arrival_dropped", 64'(want.arrival_dropped),
                             64'(seen.arrival_dropped));
                report_field("all_wait_total", 64'(want.all_wait_total),
                             64'(seen.all_wait_total));
                report_field("priority_wait_total", 64'(want.priority_wait_total),
                             64'(seen.priority_wait_total));
                report_field("general_wait_total", 64'(want.general_wait_total),
                             64'(seen.general_wait_total));
                report_field("all_arrivals", 64'(want.all_arrivals), 64'(seen.all_arrivals));
                report_field("priority_arrivals", 64'(want.priority_arrivals),
                             64'(seen.priority_arrivals));
                report_field("general_arrivals", 64'(want.general_arrivals),
                             64'(seen.general_arrivals));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        load_t mode;
        int    span;
        bit    tx_steady;
        pri_head = 0; pri_tail = 0; gen_head = 0; gen_tail = 0;
        svc_left = '0; tick_now = '0; id_next = '0;
        sum_all = '0; sum_pri = '0; sum_gen = '0;
        arr_all = '0; arr_pri = '0; arr_gen = '0;

        // typed rows: idle tick, first starts and their waits after reset
        drill_rows.push_back(row(0, CLASS_PRI, 4'hF, 1,
                                 hand_result(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        drill_rows.push_back(row(1, CLASS_PRI, 4'd3, 1,
                                 hand_result(1, 1, 0, 0, 3, 0, 0, 0, 0, 1, 1, 0)));
        drill_rows.push_back(row(1, CLASS_GEN, 4'hF, 1,
                                 hand_result(0, 0, 0, 0, 2, 0, 0, 0, 0, 2, 1, 1)));
        drill_rows.push_back(row(1, CLASS_PRI, 4'd0, 1,
                                 hand_result(0, 0, 0, 0, 1, 0, 0, 0, 0, 3, 2, 1)));
        drill_rows.push_back(row(0, CLASS_GEN, 4'hA, 1,
                                 hand_result(0, 0, 0, 0, 0, 0, 0, 0, 0, 3, 2, 1)));
        drill_rows.push_back(row(0, CLASS_GEN, 4'd0, 1,
                                 hand_result(1, 1, 2, 2, 0, 0, 2, 2, 0, 3, 2, 1)));
        drill_rows.push_back(row(0, CLASS_PRI, 4'd5, 1,
                                 hand_result(1, 0, 1, 4, 15, 0, 6, 2, 4, 3, 2, 1)));
        drill_rows.push_back(row(1, CLASS_GEN, 4'd1, 0, '0));
        drill_rows.push_back(row(1, CLASS_PRI, 4'hF, 0, '0));
        drill_rows.push_back(row(1, CLASS_GEN, 4'd0, 0, '0));
        drill_rows.push_back(row(1, CLASS_PRI, 4'd8, 0, '0));
        drill_rows.push_back(row(0, CLASS_PRI, 4'd5, 0, '0));
        drill_rows.push_back(row(1, CLASS_PRI, 4'd4, 0, '0));
        drill_rows.push_back(row(1, CLASS_GEN, 4'd2, 0, '0));
        drill_rows.push_back(row(0, CLASS_PRI, 4'hF, 0, '0));
        drill_rows.push_back(row(0, CLASS_GEN, 4'hF, 0, '0));
        drill_rows.push_back(row(0, CLASS_PRI, 4'd0, 0, '0));
        drill_rows.push_back(row(0, CLASS_GEN, 4'd6, 0, '0));
        drill_rows.push_back(row(0, CLASS_PRI, 4'd9, 0, '0));
        drill_rows.push_back(row(0, CLASS_GEN, 4'd3, 0, '0));
        drill_rows.push_back(row(0, CLASS_PRI, 4'hC, 0, '0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (drill_rows[i])
            issue_tick(drill_rows[i].req, drill_rows[i].known, drill_rows[i].res,
                       gap_cycles());

        // hold off until the pipeline has drained
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);

        // fill both queues first so drops are seen, then random load phases
        for (int ph = 0; n_ticks < TICK_TARGET; ph++) begin
            if (ph == 0) begin
                mode = LOAD_PRI_FLOOD;
                span = 300;
            end else if (ph == 1) begin
                mode = LOAD_GEN_FLOOD;
                span = 300;
            end else begin
                mode = load_t'($urandom_range(0, 4));
                span = $urandom_range(40, 150);
            end
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < span && n_ticks < TICK_TARGET; k++)
                issue_tick(random_tick(mode), 1'b0, '0, tx_steady ? 0 : gap_cycles());
        end
        s_axis_tvalid <= 1'b0;
        rx_steady = 1'b0;

        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (10) @(posedge aclk);

        $display("Covered %0d ticks: %0d starts (%0d priority), %0d dropped arrivals.",
                 n_ticks, n_starts, n_pri_starts, n_drops);
        $display("Both queues were filled to capacity; zero-length service was included.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
